// ----- rtl/core/svenv_pkg.sv -----
package svenv_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd4;

    // opcodes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ATTACK = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [7:0] SAMPLE_MIN = 8'd5;
    localparam logic [7:0] SAMPLE_MAX = 8'd250;
    localparam logic [7:0] SAMPLE_IDLE = 8'd5;
    localparam logic [7:0] VOL_FULL = 8'hFF;
    localparam logic [15:0] LFSR_SEED = 16'hFFFF;

    typedef struct packed {
        logic [3:0] wave_en;
        logic [7:0] pulse_width;
        logic [7:0] attack_period;
        logic [7:0] decay_period;
        logic [7:0] sustain_level;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        wave_en: 4'd0,
        pulse_width: 8'd127,
        attack_period: 8'd1,
        decay_period: 8'd0,
        sustain_level: 8'd0
    };

    typedef struct packed {
        logic [7:0] level;
        logic       busy;
    } t_env_out;

    // decay pacing gets slower as the volume gets quiet
    function automatic logic [7:0] rate_for_volume(input logic [7:0] v);
        logic [7:0] r;
        if (v < 8'd7) begin
            r = 8'd30;
        end else if (v < 8'd15) begin
            r = 8'd16;
        end else if (v < 8'd27) begin
            r = 8'd8;
        end else if (v < 8'd55) begin
            r = 8'd4;
        end else if (v < 8'd94) begin
            r = 8'd2;
        end else begin
            r = 8'd1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/svenv_voice.sv -----
module svenv_voice
    import svenv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [15:0] i_freq_step,
    input  t_cfg        i_cfg,
    output logic [7:0]  o_wave
);

    logic [15:0] r_phase_acc, n_phase_acc;
    logic [15:0] r_lfsr, n_lfsr;
    logic [7:0]  r_noise, n_noise;
    logic [7:0]  r_prev_saw;
    logic [7:0]  saw;
    logic [7:0]  tri_wave;
    logic [7:0]  pulse;

    always_comb begin
        n_phase_acc = r_phase_acc + i_freq_step;
        saw = n_phase_acc[15:8];
        n_lfsr = r_lfsr;
        n_noise = r_noise;
        // noise shifts on each half-period crossing of the saw
        if (saw[7] != r_prev_saw[7]) begin
            n_lfsr = {r_lfsr[14:0], r_lfsr[14] ^ r_lfsr[13]};
            n_noise = n_lfsr[7:0];
        end
        tri_wave = {saw[6:0], 1'b0} ^ {8{saw[7]}};
        pulse = (saw > i_cfg.pulse_width) ? 8'h00 : 8'hFF;
        o_wave = 8'hFF;
        if (i_cfg.wave_en[0]) begin
            o_wave = o_wave & n_noise;
        end
        if (i_cfg.wave_en[1]) begin
            o_wave = o_wave & pulse;
        end
        if (i_cfg.wave_en[2]) begin
            o_wave = o_wave & tri_wave;
        end
        if (i_cfg.wave_en[3]) begin
            o_wave = o_wave & saw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
            r_lfsr <= LFSR_SEED;
            r_noise <= '0;
            r_prev_saw <= '0;
        end else if (i_adv) begin
            r_phase_acc <= n_phase_acc;
            r_lfsr <= n_lfsr;
            r_noise <= n_noise;
            r_prev_saw <= saw;
        end
    end

endmodule

// ----- rtl/core/svenv_env.sv -----
module svenv_env
    import svenv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_run,
    input  logic [1:0] i_opcode,
    input  t_cfg       i_cfg,
    output t_env_out   o_env
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ATTACK  = 4'b0010,
        ST_SUSTAIN = 4'b0100,
        ST_RELEASE = 4'b1000
    } t_env_state;

    t_env_state r_state, n_state;
    logic [7:0] r_volume, n_volume;
    logic [7:0] r_step_count, n_step_count;
    logic [7:0] r_step_period, n_step_period;
    logic [7:0] r_decay_count, n_decay_count;
    logic [7:0] r_decay_rate, n_decay_rate;
    logic [7:0] step_inc;
    logic [7:0] decay_inc;
    logic [7:0] vol_dec;

    always_comb begin
        n_state = r_state;
        n_step_period = r_step_period;
        n_volume = r_volume;
        n_decay_count = r_decay_count;
        n_decay_rate = r_decay_rate;
        vol_dec = r_volume;
        // opcode applies before the tick
        if (i_opcode == OP_ATTACK) begin
            n_state = ST_ATTACK;
            n_step_period = i_cfg.attack_period;
        end else if (i_opcode == OP_RELEASE) begin
            n_state = ST_RELEASE;
        end
        step_inc = r_step_count + 8'd1;
        decay_inc = r_decay_count + 8'd1;
        n_step_count = step_inc;
        if (step_inc >= n_step_period) begin
            n_step_count = '0;
            case (n_state)
                ST_IDLE: begin
                end
                ST_ATTACK: begin
                    n_volume = r_volume + 8'd1;
                    if (n_volume == VOL_FULL) begin
                        n_state = ST_SUSTAIN;
                        n_step_period = i_cfg.decay_period;
                    end
                end
                ST_SUSTAIN, ST_RELEASE: begin
                    n_decay_count = decay_inc;
                    if (decay_inc >= r_decay_rate) begin
                        n_decay_count = '0;
                        // sustain holds only at exactly the target level
                        if (i_cfg.sustain_level != r_volume ||
                            n_state == ST_RELEASE) begin
                            vol_dec = r_volume - 8'd1;
                        end
                        n_volume = vol_dec;
                        if (vol_dec == 8'd0) begin
                            n_decay_rate = 8'd1;
                            n_state = ST_IDLE;
                        end else begin
                            n_decay_rate = rate_for_volume(vol_dec);
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        if (i_run) begin
            o_env.level = n_volume;
            o_env.busy = (n_state != ST_IDLE);
        end else begin
            o_env.level = r_volume;
            o_env.busy = (r_state != ST_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_volume <= '0;
            r_step_count <= '0;
            r_step_period <= 8'd1;
            r_decay_count <= '0;
            r_decay_rate <= 8'd1;
        end else if (i_adv) begin
            r_state <= n_state;
            r_volume <= n_volume;
            r_step_count <= n_step_count;
            r_step_period <= n_step_period;
            r_decay_count <= n_decay_count;
            r_decay_rate <= n_decay_rate;
        end
    end

endmodule

// ----- rtl/core/svenv_scale.sv -----
module svenv_scale
    import svenv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_load,
    input  logic       i_on,
    input  logic [7:0] i_wave,
    input  logic [7:0] i_volume,
    output logic [7:0] o_sample
);

    logic [15:0] prod;
    logic [7:0]  scaled;
    logic [7:0]  n_sample;
    logic [7:0]  r_sample;

    always_comb begin
        prod = 16'(i_wave) * 16'(i_volume);
        scaled = prod[15:8];
        if (!i_on) begin
            n_sample = SAMPLE_IDLE;
        end else if (scaled < SAMPLE_MIN) begin
            n_sample = SAMPLE_MIN;
        end else if (scaled > SAMPLE_MAX) begin
            n_sample = SAMPLE_MAX;
        end else begin
            n_sample = scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

// ----- rtl/core/synth_voice_with_envelope.sv -----
// One synthesizer voice (saw, triangle, pulse and noise ANDed together) scaled by an
// attack/sustain/release envelope, one sample per transaction. A new transaction is
// taken every cycle while the output side is not stalled; each result goes through the
// input register, then the state and waveform register, then multiply and clamp into
// the output register before it is presented. All voice and envelope state advances
// once per tick, which is what sets the one-per-cycle rate.
// When the output is stalled the whole pipeline holds and the input stall follows it in
// the same cycle. Configuration writes are meant for when no transaction is in flight.
module synth_voice_with_envelope
    import svenv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [15:0]           i_freq_step,
    input  logic                  i_voice_on,
    input  logic [1:0]            i_opcode,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_sample,
    output logic [7:0]            o_env_level,
    output logic                  o_env_busy
);

    t_cfg r_cfg;

    logic        en;
    logic        adv;
    logic        r_a_vld;
    logic [15:0] r_a_step;
    logic        r_a_on;
    logic [1:0]  r_a_op;
    logic        r_b_vld;
    logic        r_b_on;
    logic [7:0]  r_b_wave;
    t_env_out    r_b_env;
    logic        r_out_vld;
    t_env_out    r_out_env;
    logic [7:0]  wave;
    t_env_out    env;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WAVE_EN: r_cfg.wave_en <= i_cfg_data[3:0];
                CFG_PULSE_WIDTH: r_cfg.pulse_width <= i_cfg_data;
                CFG_ATTACK_PERIOD: r_cfg.attack_period <= i_cfg_data;
                CFG_DECAY_PERIOD: r_cfg.decay_period <= i_cfg_data;
                CFG_SUSTAIN_LEVEL: r_cfg.sustain_level <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // all stages move together whenever the output register is free or being taken
    assign en = !r_out_vld || !i_out_stall;
    assign o_in_stall = !en;
    assign adv = en && r_a_vld && r_a_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_step <= i_freq_step;
            r_a_on <= i_voice_on;
            r_a_op <= i_opcode;
            r_b_on <= r_a_on;
            r_b_wave <= wave;
            r_b_env <= env;
            r_out_env <= r_b_env;
        end
    end

    svenv_voice u_voice (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_freq_step (r_a_step),
        .i_cfg       (r_cfg),
        .o_wave      (wave)
    );

    svenv_env u_env (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_run    (r_a_on),
        .i_opcode (r_a_op),
        .i_cfg    (r_cfg),
        .o_env    (env)
    );

    svenv_scale u_scale (
        .i_clk    (i_clk),
        .i_load   (en),
        .i_on     (r_b_on),
        .i_wave   (r_b_wave),
        .i_volume (r_b_env.level),
        .o_sample (o_sample)
    );

    assign o_out_valid = r_out_vld;
    assign o_env_level = r_out_env.level;
    assign o_env_busy = r_out_env.busy;

`ifndef NO_ASSERTIONS
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample >= SAMPLE_MIN) && (o_sample <= SAMPLE_MAX))
        else $error("sample outside clamp range");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_env_busy) |-> (o_env_level == 8'd0))
        else $error("idle envelope with nonzero level");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_a_vld)
        else $error("accepted transaction lost at input register");
`endif

endmodule
